// ===== sv/smm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_pkg
// Shared constants, types and the microcode table of the small matrix
// multiplier.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;

  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int MUL_W   = 2 * ELEM_WIDTH;

  localparam int CFG_W   = 4;
  localparam int POS_W   = 3;
  localparam int PROD_W  = 34;
  localparam int ACT_W   = 2;
  localparam int ELEM_IN_W = 16;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 40;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam int STEP_W  = 4;
  localparam int N_STEPS = 9;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_A  = 2'd0,
    ACT_LOAD_B  = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_ROWS_A = 2'd0,
    REG_COLS_A = 2'd1,
    REG_ROWS_B = 2'd2,
    REG_COLS_B = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_START,
    C_DIMERR,
    C_KLAST,
    C_OUTFREE,
    C_MORE
  } cond_e;

  typedef enum logic [1:0] {
    F_NEXT,
    F_HOLD,
    F_IDLE
  } fail_e;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_SETUP  = 4'd1;
  localparam step_t ST_ROW    = 4'd2;
  localparam step_t ST_LOOP   = 4'd3;
  localparam step_t ST_DRAIN1 = 4'd4;
  localparam step_t ST_DRAIN2 = 4'd5;
  localparam step_t ST_EMIT   = 4'd6;
  localparam step_t ST_ADV    = 4'd7;
  localparam step_t ST_ERR    = 4'd8;

  typedef struct packed {
    logic accept;
    logic clr_ij;
    logic clr_k;
    logic issue;
    logic emit;
    logic emit_err;
    logic adv;
  } ctrl_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_e cond;
    fail_e on_false;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic start;
    logic dim_err;
    logic k_last;
    logic out_free;
    logic more;
  } stat_t;

  typedef struct packed {
    logic [CFG_W-1:0] rows_a;
    logic [CFG_W-1:0] cols_a;
    logic [CFG_W-1:0] rows_b;
    logic [CFG_W-1:0] cols_b;
  } dims_t;

  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    w          = '0;
    w.cond     = C_ALWAYS;
    w.on_false = F_NEXT;
    w.target   = ST_IDLE;
    case (s)
      ST_IDLE: begin
        w.ctrl.accept = 1'b1;
        w.cond        = C_START;
        w.on_false    = F_HOLD;
        w.target      = ST_SETUP;
      end
      ST_SETUP: begin
        w.ctrl.clr_ij = 1'b1;
        w.cond        = C_DIMERR;
        w.on_false    = F_NEXT;
        w.target      = ST_ERR;
      end
      ST_ROW: begin
        w.ctrl.clr_k = 1'b1;
        w.target     = ST_LOOP;
      end
      ST_LOOP: begin
        w.ctrl.issue = 1'b1;
        w.cond       = C_KLAST;
        w.on_false   = F_HOLD;
        w.target     = ST_DRAIN1;
      end
      ST_DRAIN1: begin
        w.target = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        w.target = ST_EMIT;
      end
      ST_EMIT: begin
        w.ctrl.emit = 1'b1;
        w.cond      = C_OUTFREE;
        w.on_false  = F_HOLD;
        w.target    = ST_ADV;
      end
      ST_ADV: begin
        w.ctrl.adv = 1'b1;
        w.cond     = C_MORE;
        w.on_false = F_IDLE;
        w.target   = ST_ROW;
      end
      ST_ERR: begin
        w.ctrl.emit_err = 1'b1;
        w.cond          = C_OUTFREE;
        w.on_false      = F_HOLD;
        w.target        = ST_IDLE;
      end
      default: begin
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  // Zero acts as one, anything above the store size as the store size.
  function automatic logic [DIM_W-1:0] clamp_dim(logic [CFG_W-1:0] r);
    logic [DIM_W-1:0] d;
    if (r == '0) begin
      d = DIM_W'(1);
    end else if (r > MAX_DIM) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = DIM_W'(r);
    end
    return d;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [IDX_W-1:0] r,
                                                  logic [IDX_W-1:0] c);
    return ADDR_W'(r * MAX_DIM + c);
  endfunction

endpackage

// ===== sv/smm_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_store
// Element store of one matrix: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module smm_store import smm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_W-1:0]     waddr_i,
  input  logic [ELEM_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [ADDR_W-1:0]     raddr_i,
  output logic [ELEM_WIDTH-1:0] rdata_o
);

  logic [ELEM_WIDTH-1:0] mem [CELLS];
  logic [ELEM_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/smm_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_seq
// Microcode sequencer: step counter, control word table and conditional
// jumps.
// ----------------------------------------------------------------------------
module smm_seq import smm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  step_t  pc_q, pc_d;
  uword_t word;
  logic   hit;

  assign word = ucode_rom(pc_q);

  always_comb begin
    case (word.cond)
      C_ALWAYS:  hit = 1'b1;
      C_START:   hit = stat_i.start;
      C_DIMERR:  hit = stat_i.dim_err;
      C_KLAST:   hit = stat_i.k_last;
      C_OUTFREE: hit = stat_i.out_free;
      C_MORE:    hit = stat_i.more;
      default:   hit = 1'b1;
    endcase
  end

  always_comb begin
    if (hit) begin
      pc_d = word.target;
    end else begin
      case (word.on_false)
        F_NEXT:  pc_d = pc_q + STEP_W'(1);
        F_HOLD:  pc_d = pc_q;
        F_IDLE:  pc_d = ST_IDLE;
        default: pc_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = word.ctrl;

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q < STEP_W'(N_STEPS))
    else $error("step counter outside program");

endmodule

// ===== sv/smm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_dp
// Datapath: element stores, index counters, multiply-accumulate pipeline
// and result register.
// ----------------------------------------------------------------------------
module smm_dp import smm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_t            ctrl_i,
  output stat_t            stat_o,
  input  dims_t            dims_i,
  input  logic             s_axis_tvalid_i,
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o,
  output logic             m_axis_tlast_o,
  output logic             m_axis_tuser_o
);

  action_e                      action;
  logic [POS_W-1:0]             row_in, col_in;
  logic signed [ELEM_IN_W-1:0]  elem_in;
  logic                         in_range, take;

  logic [DIM_W-1:0]             ra, ca, rb, cb, nr, nc, nk;
  logic                         ba, dim_err, last_el;

  logic [IDX_W-1:0]             i_q, j_q, k_q;
  logic [ADDR_W-1:0]            waddr, raddr_a, raddr_b;
  logic [ELEM_WIDTH-1:0]        wdata;
  logic                         we_a, we_b;
  logic signed [ELEM_WIDTH-1:0] rd_a, rd_b;

  logic                         rd_v_q, mul_v_q;
  logic signed [MUL_W-1:0]      mul_q;
  logic signed [PROD_W-1:0]     acc_q;

  logic                         out_v_q, out_free;
  logic [POS_W-1:0]             out_row_q, out_col_q;
  logic [PROD_W-1:0]            out_prod_q;
  logic                         out_last_q, out_err_q;

  assign action   = action_e'(s_axis_tdata_i[1:0]);
  assign row_in   = s_axis_tdata_i[4:2];
  assign col_in   = s_axis_tdata_i[7:5];
  assign elem_in  = $signed(s_axis_tdata_i[23:8]);
  assign take     = s_axis_tvalid_i && ctrl_i.accept;
  assign in_range = (row_in < MAX_DIM) && (col_in < MAX_DIM);

  assign waddr = cell_addr(IDX_W'(row_in), IDX_W'(col_in));
  assign wdata = ELEM_WIDTH'(elem_in);
  assign we_a  = take && in_range && (action == ACT_LOAD_A);
  assign we_b  = take && in_range && (action == ACT_LOAD_B);

  assign ra      = clamp_dim(dims_i.rows_a);
  assign ca      = clamp_dim(dims_i.cols_a);
  assign rb      = clamp_dim(dims_i.rows_b);
  assign cb      = clamp_dim(dims_i.cols_b);
  assign ba      = (ra == cb);
  assign dim_err = !ba && (ca != rb);
  assign nr      = ba ? rb : ra;
  assign nc      = ba ? ca : cb;
  assign nk      = ba ? ra : ca;
  assign last_el = (i_q == IDX_W'(nr - DIM_W'(1))) && (j_q == IDX_W'(nc - DIM_W'(1)));

  assign raddr_a = ba ? cell_addr(k_q, j_q) : cell_addr(i_q, k_q);
  assign raddr_b = ba ? cell_addr(i_q, k_q) : cell_addr(k_q, j_q);

  smm_store u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctrl_i.issue),
    .raddr_i (raddr_a),
    .rdata_o (rd_a)
  );

  smm_store u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctrl_i.issue),
    .raddr_i (raddr_b),
    .rdata_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
    end else begin
      rd_v_q  <= ctrl_i.issue;
      mul_v_q <= rd_v_q;
      if (ctrl_i.clr_ij) begin
        i_q <= '0;
        j_q <= '0;
      end else if (ctrl_i.adv) begin
        if (j_q == IDX_W'(nc - DIM_W'(1))) begin
          j_q <= '0;
          i_q <= i_q + IDX_W'(1);
        end else begin
          j_q <= j_q + IDX_W'(1);
        end
      end
      if (ctrl_i.clr_k) begin
        k_q <= '0;
      end else if (ctrl_i.issue) begin
        k_q <= k_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= rd_a * rd_b;
    if (ctrl_i.clr_k) begin
      acc_q <= '0;
    end else if (mul_v_q) begin
      acc_q <= acc_q + PROD_W'(mul_q);
    end
  end

  assign out_free = !out_v_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if ((ctrl_i.emit || ctrl_i.emit_err) && out_free) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit && out_free) begin
      out_row_q  <= POS_W'(i_q);
      out_col_q  <= POS_W'(j_q);
      out_prod_q <= acc_q;
      out_last_q <= last_el;
      out_err_q  <= 1'b0;
    end else if (ctrl_i.emit_err && out_free) begin
      out_row_q  <= '0;
      out_col_q  <= '0;
      out_prod_q <= '0;
      out_last_q <= 1'b1;
      out_err_q  <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_prod_q, out_col_q, out_row_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_err_q;

  assign stat_o.start    = take && (action == ACT_COMPUTE);
  assign stat_o.dim_err  = dim_err;
  assign stat_o.k_last   = (k_q == IDX_W'(nk - DIM_W'(1)));
  assign stat_o.out_free = out_free;
  assign stat_o.more     = !last_el;

  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit |-> !rd_v_q && !mul_v_q)
    else $error("result taken before accumulation finished");

  a_issue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.issue |-> (DIM_W'(k_q) < nk))
    else $error("inner index beyond inner dimension");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("dimension error item not marked last");

endmodule

// ===== sv/small_matrix_multiply.sv =====
`timescale 1ns / 1ps
// Load items: one per cycle, back to back, while idle; no result.
// Compute item: nr*nc results, computed one after another on the single
// multiply-accumulate unit with one store read per cycle; no new item is
// taken until the last result has gone to the output register.
// Dimension mismatch: one error item instead of products.
// Reset: registers return to 1, sequencer to idle; stores are not cleared.
// ----------------------------------------------------------------------------
// small_matrix_multiply
// Two small signed matrices loaded element by element, product emitted row
// by row under control of a microcoded sequencer.
// ----------------------------------------------------------------------------
module small_matrix_multiply import smm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // action[1:0], row_index[4:2], col_index[7:5], element[23:8]
  input  logic [IN_W-1:0]    s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // out_row[2:0], out_col[5:3], product[39:6]
  output logic [OUT_W-1:0]   m_axis_tdata_o,
  output logic               m_axis_tlast_o,
  // dim_error[0]
  output logic               m_axis_tuser_o
);

  dims_t dims_q;
  ctrl_t ctrl;
  stat_t stat;
  reg_e  reg_sel;
  logic  wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q.rows_a <= CFG_W'(1);
      dims_q.cols_a <= CFG_W'(1);
      dims_q.rows_b <= CFG_W'(1);
      dims_q.cols_b <= CFG_W'(1);
    end else if (wr_en) begin
      case (reg_sel)
        REG_ROWS_A: dims_q.rows_a <= pwdata[CFG_W-1:0];
        REG_COLS_A: dims_q.cols_a <= pwdata[CFG_W-1:0];
        REG_ROWS_B: dims_q.rows_b <= pwdata[CFG_W-1:0];
        REG_COLS_B: dims_q.cols_b <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ROWS_A: prdata = PDATA_W'(dims_q.rows_a);
      REG_COLS_A: prdata = PDATA_W'(dims_q.cols_a);
      REG_ROWS_B: prdata = PDATA_W'(dims_q.rows_b);
      REG_COLS_B: prdata = PDATA_W'(dims_q.cols_b);
      default:    prdata = '0;
    endcase
  end

  smm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  smm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .dims_i          (dims_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  assign s_axis_tready_o = ctrl.accept;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the small matrix multiplier. A short table of
// directed items checks reset dimensions, element extremes, the unused
// action, the dimension error and register clamping. Random phases then set
// the dimensions, load the matrices and request products. Every product item
// is checked against a fixed value from the table or an in-bench model of
// the stores, under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_top;
  import smm_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int ITEM_TARGET = 500;
  localparam int SETTLE      = 16;

  typedef struct packed {
    action_e     act;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [15:0] elem;
  } mat_item_t;

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [33:0] product;
    logic        last;
    logic        dim_err;
  } prod_elem_t;

  typedef struct packed {
    logic       is_cfg;
    reg_e       reg_idx;
    logic [3:0] reg_val;
    mat_item_t  item;
    logic       typed;
    prod_elem_t want;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni   = 1'b0;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [PDATA_W-1:0] pwdata   = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  // action[1:0], row_index[4:2], col_index[7:5], element[23:8]
  logic [IN_W-1:0]    s_tdata  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // out_row[2:0], out_col[5:3], product[39:6]
  logic [OUT_W-1:0]   m_tdata;
  logic               m_tlast;
  // dim_error[0]
  logic               m_tuser;

  logic signed [15:0] a_cells [CELLS];
  logic signed [15:0] b_cells [CELLS];
  bit                 a_written [CELLS];
  bit                 b_written [CELLS];
  logic [3:0]         rows_a_reg = 4'd1;
  logic [3:0]         cols_a_reg = 4'd1;
  logic [3:0]         rows_b_reg = 4'd1;
  logic [3:0]         cols_b_reg = 4'd1;

  prod_elem_t expected_elems [$];
  dir_row_t   directed [$];
  int         errors      = 0;
  int         items_sent  = 0;
  int         burst_left  = 0;
  int         quiet_cycles = 0;
  int         stall_pct   = 0;
  int         stall_left  = 0;
  int         stall_streak = 0;

  small_matrix_multiply dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int active_dim(logic [3:0] raw);
    if (raw == 4'd0) begin
      return 1;
    end else if (raw > MAX_DIM) begin
      return MAX_DIM;
    end
    return int'(raw);
  endfunction

  function automatic mat_item_t make_item(action_e act, int r, int c, logic [15:0] e);
    mat_item_t it;
    it.act  = act;
    it.row  = 3'(r);
    it.col  = 3'(c);
    it.elem = e;
    return it;
  endfunction

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_dim();
    int p;
    p = $urandom_range(0, 19);
    if (p < 14) begin
      return 4'($urandom_range(1, 4));
    end else if (p < 17) begin
      return 4'($urandom_range(5, 8));
    end else if (p == 17) begin
      return 4'd0;
    end else if (p == 18) begin
      return 4'd15;
    end
    return 4'($urandom_range(9, 15));
  endfunction

  // Pick a raw value that clamps to the same dimension.
  function automatic logic [3:0] same_dim(logic [3:0] raw);
    if (raw <= 4'd1) begin
      return 4'($urandom_range(0, 1));
    end else if (raw >= MAX_DIM) begin
      return 4'($urandom_range(MAX_DIM, 15));
    end
    return raw;
  endfunction

  task automatic apply_item(input mat_item_t it);
    int ra, ca, rb, cb, nr, nc, nk, i, j, k;
    bit ba;
    longint acc;
    prod_elem_t res;
    case (it.act)
      ACT_LOAD_A: begin
        a_cells[{it.row, it.col}]   = it.elem;
        a_written[{it.row, it.col}] = 1'b1;
      end
      ACT_LOAD_B: begin
        b_cells[{it.row, it.col}]   = it.elem;
        b_written[{it.row, it.col}] = 1'b1;
      end
      ACT_COMPUTE: begin
        ra = active_dim(rows_a_reg);
        ca = active_dim(cols_a_reg);
        rb = active_dim(rows_b_reg);
        cb = active_dim(cols_b_reg);
        res = '0;
        if (ra == cb) begin
          ba = 1'b1; nr = rb; nc = ca; nk = ra;
        end else if (ca == rb) begin
          ba = 1'b0; nr = ra; nc = cb; nk = ca;
        end else begin
          nr = 0; nc = 0; nk = 0; ba = 1'b0;
          res.last    = 1'b1;
          res.dim_err = 1'b1;
          expected_elems.push_back(res);
        end
        for (i = 0; i < nr; i++) begin
          for (j = 0; j < nc; j++) begin
            acc = 0;
            for (k = 0; k < nk; k++) begin
              if (ba) begin
                acc += longint'(b_cells[i * MAX_DIM + k]) * longint'(a_cells[k * MAX_DIM + j]);
              end else begin
                acc += longint'(a_cells[i * MAX_DIM + k]) * longint'(b_cells[k * MAX_DIM + j]);
              end
            end
            res.row     = 3'(i);
            res.col     = 3'(j);
            res.product = 34'(acc);
            res.last    = (i == nr - 1) && (j == nc - 1);
            res.dim_err = 1'b0;
            expected_elems.push_back(res);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(input mat_item_t it, input bit predict);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {it.elem, it.col, it.row, it.act};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    burst_left--;
    if (it.act != ACT_NONE) begin
      items_sent++;
    end
    if (predict) begin
      apply_item(it);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_elems.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [3:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= PDATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ROWS_A: rows_a_reg = val;
      REG_COLS_A: cols_a_reg = val;
      REG_ROWS_B: rows_b_reg = val;
      default:    cols_b_reg = val;
    endcase
    @(posedge clk_i);
  endtask

  task automatic add_cfg(input reg_e idx, input logic [3:0] val);
    dir_row_t d;
    d         = '0;
    d.is_cfg  = 1'b1;
    d.reg_idx = idx;
    d.reg_val = val;
    directed.push_back(d);
  endtask

  task automatic add_item(input action_e act, input int r, input int c, input logic [15:0] e);
    dir_row_t d;
    d      = '0;
    d.item = make_item(act, r, c, e);
    directed.push_back(d);
  endtask

  task automatic add_typed(input logic [33:0] prod, input logic err);
    dir_row_t d;
    d              = '0;
    d.item         = make_item(ACT_COMPUTE, 0, 0, 16'h0000);
    d.typed        = 1'b1;
    d.want.product = prod;
    d.want.last    = 1'b1;
    d.want.dim_err = err;
    directed.push_back(d);
  endtask

  task automatic run_phase();
    logic [3:0] ra_raw, ca_raw, rb_raw, cb_raw;
    int mode, ra, ca, rb, cb, r, c, i, j, n;
    bit fill;
    mat_item_t q [$];
    mat_item_t tmp;
    ra_raw = pick_dim();
    ca_raw = pick_dim();
    rb_raw = pick_dim();
    cb_raw = pick_dim();
    mode   = $urandom_range(0, 9);
    fill   = ($urandom_range(0, 19) == 0);
    if (mode >= 1 && mode <= 5) begin
      cb_raw = same_dim(ra_raw);
    end else if (mode >= 6) begin
      rb_raw = same_dim(ca_raw);
    end
    wait_idle();
    write_reg(REG_ROWS_A, ra_raw);
    write_reg(REG_COLS_A, ca_raw);
    write_reg(REG_ROWS_B, rb_raw);
    write_reg(REG_COLS_B, cb_raw);
    ra = active_dim(ra_raw);
    ca = active_dim(ca_raw);
    rb = active_dim(rb_raw);
    cb = active_dim(cb_raw);
    for (r = 0; r < ra; r++) begin
      for (c = 0; c < ca; c++) begin
        if (fill || !a_written[r * MAX_DIM + c] || $urandom_range(0, 99) < 60) begin
          q.push_back(make_item(ACT_LOAD_A, r, c, fill ? 16'h8000 : rand_elem()));
        end
      end
    end
    for (r = 0; r < rb; r++) begin
      for (c = 0; c < cb; c++) begin
        if (fill || !b_written[r * MAX_DIM + c] || $urandom_range(0, 99) < 60) begin
          q.push_back(make_item(ACT_LOAD_B, r, c, fill ? 16'h8000 : rand_elem()));
        end
      end
    end
    n = fill ? 0 : $urandom_range(0, 3);
    repeat (n) begin
      q.push_back(make_item($urandom_range(0, 1) ? ACT_LOAD_B : ACT_LOAD_A,
                            $urandom_range(0, 7), $urandom_range(0, 7), rand_elem()));
    end
    if ($urandom_range(0, 4) == 0) begin
      q.push_back(make_item(ACT_NONE, $urandom_range(0, 7), $urandom_range(0, 7), rand_elem()));
    end
    for (i = q.size() - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      tmp  = q[i];
      q[i] = q[j];
      q[j] = tmp;
    end
    q.push_back(make_item(ACT_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), rand_elem()));
    if ($urandom_range(0, 4) == 0) begin
      q.push_back(make_item(ACT_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
                            rand_elem()));
    end
    foreach (q[k]) begin
      send_item(q[k], 1'b1);
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 25;
        2: stall_pct <= 60;
        default: stall_pct <= 90;
      endcase
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    if (stall_streak >= 12 || $urandom_range(0, 99) >= stall_pct) begin
      m_tready     <= 1'b1;
      stall_streak <= 0;
    end else begin
      m_tready     <= 1'b0;
      stall_streak <= stall_streak + 1;
    end
  end

  always @(posedge clk_i) begin
    prod_elem_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_elems.size() == 0) begin
        $error("unexpected product item: row %0d col %0d", m_tdata[2:0], m_tdata[5:3]);
        errors++;
      end else begin
        want = expected_elems.pop_front();
        if (m_tdata[2:0] !== want.row) begin
          $error("out_row mismatch: expected %0d, actual %0d", want.row, m_tdata[2:0]);
          errors++;
        end
        if (m_tdata[5:3] !== want.col) begin
          $error("out_col mismatch: expected %0d, actual %0d", want.col, m_tdata[5:3]);
          errors++;
        end
        if (m_tdata[39:6] !== want.product) begin
          $error("product mismatch: expected %0d, actual %0d",
                 $signed(want.product), $signed(m_tdata[39:6]));
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, m_tlast);
          errors++;
        end
        if (m_tuser !== want.dim_err) begin
          $error("dim_error mismatch: expected %0d, actual %0d", want.dim_err, m_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    bit in_cfg;
    in_cfg = 1'b0;

    add_item(ACT_LOAD_A, 0, 0, 16'h8000);
    add_item(ACT_LOAD_B, 0, 0, 16'h8000);
    add_typed(34'sd1073741824, 1'b0);
    add_item(ACT_NONE, 7, 7, 16'hFFFF);
    add_item(ACT_LOAD_A, 0, 0, 16'h7FFF);
    add_typed(-34'sd1073709056, 1'b0);
    add_cfg(REG_ROWS_A, 4'd2);
    add_cfg(REG_COLS_A, 4'd3);
    add_cfg(REG_ROWS_B, 4'd4);
    add_cfg(REG_COLS_B, 4'd5);
    add_typed(34'sd0, 1'b1);
    add_cfg(REG_ROWS_A, 4'd0);
    add_cfg(REG_COLS_A, 4'd0);
    add_cfg(REG_ROWS_B, 4'd15);
    add_cfg(REG_COLS_B, 4'd0);
    add_item(ACT_LOAD_B, 1, 0, 16'h7FFF);
    add_item(ACT_LOAD_B, 2, 0, 16'h8000);
    add_item(ACT_LOAD_B, 3, 0, 16'hFFFF);
    add_item(ACT_LOAD_B, 4, 0, 16'h0000);
    add_item(ACT_LOAD_B, 5, 0, 16'h0001);
    add_item(ACT_LOAD_B, 6, 0, 16'h5555);
    add_item(ACT_LOAD_B, 7, 0, 16'hAAAA);
    add_item(ACT_LOAD_A, 7, 7, 16'h5A5A);
    add_item(ACT_COMPUTE, 0, 0, 16'h0000);
    add_cfg(REG_ROWS_A, 4'd2);
    add_cfg(REG_COLS_A, 4'd1);
    add_cfg(REG_ROWS_B, 4'd1);
    add_cfg(REG_COLS_B, 4'd1);
    add_item(ACT_LOAD_A, 1, 0, 16'hFFFF);
    add_item(ACT_COMPUTE, 7, 7, 16'hFFFF);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        if (!in_cfg) begin
          wait_idle();
        end
        in_cfg = 1'b1;
        write_reg(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        in_cfg = 1'b0;
        send_item(directed[i].item, !directed[i].typed);
        if (directed[i].typed) begin
          expected_elems.push_back(directed[i].want);
        end
      end
    end

    while (items_sent < ITEM_TARGET) run_phase();

    s_tvalid <= 1'b0;
    while (expected_elems.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/smm_pkg.sv
sv/smm_store.sv
sv/smm_seq.sv
sv/smm_dp.sv
sv/small_matrix_multiply.sv
tb/sv/tb_top.sv
